// ===== rtl/core/cda_pkg.sv =====
// shared types, constants and helper functions of the calendar date unit
package cda_pkg;

  typedef enum logic [1:0] {
    CMD_CONVERT    = 2'd0,
    CMD_ADD_DAYS   = 2'd1,
    CMD_ADD_MONTHS = 2'd2,
    CMD_ADD_YEARS  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t               cmd;
    status_t            st;
    logic signed [22:0] off;
  } cda_meta_t;

  localparam logic [13:0] MAX_YEAR      = 14'd9999;
  localparam logic [4:0]  FEB_SHORT_DAY = 5'd28;
  localparam logic [16:0] MAX_MONTHS    = 17'd119999;

  localparam logic signed [25:0] MIN_SERIAL  = -26'sd719528;
  localparam logic signed [25:0] MAX_SERIAL  = 26'sd2932896;
  // negated serial of day zero of the shifted 400-year era frame
  localparam logic signed [25:0] ERA_SHIFT   = 26'sd865565;
  localparam logic signed [23:0] ERA_SHIFT24 = 24'sd865565;
  // shift that makes the weekday remainder start at monday
  localparam logic signed [23:0] WDAY_SHIFT  = 24'sd719533;

  // reciprocal constants, exact for the operand ranges used
  localparam int DIV100_S = 21;
  localparam longint unsigned DIV100_M = ((64'd1 << DIV100_S) + 64'd99) / 64'd100;
  localparam int DIV12_S = 21;
  localparam longint unsigned DIV12_M = ((64'd1 << DIV12_S) + 64'd11) / 64'd12;
  localparam int DIVERA_S = 40;
  localparam longint unsigned DIVERA_M =
    ((64'd1 << DIVERA_S) + 64'd146096) / 64'd146097;
  localparam int DIV7_S = 25;
  localparam longint unsigned DIV7_M = ((64'd1 << DIV7_S) + 64'd6) / 64'd7;
  localparam int DIV1460_S = 29;
  localparam longint unsigned DIV1460_M = ((64'd1 << DIV1460_S) + 64'd1459) / 64'd1460;
  localparam int DIV36524_S = 34;
  localparam longint unsigned DIV36524_M =
    ((64'd1 << DIV36524_S) + 64'd36523) / 64'd36524;
  localparam int DIV146096_S = 36;
  localparam longint unsigned DIV146096_M =
    ((64'd1 << DIV146096_S) + 64'd146095) / 64'd146096;
  localparam int DIV365_S = 27;
  localparam longint unsigned DIV365_M = ((64'd1 << DIV365_S) + 64'd364) / 64'd365;
  localparam int DIV153_S = 19;
  localparam longint unsigned DIV153_M = ((64'd1 << DIV153_S) + 64'd152) / 64'd153;
  localparam int DIV5_S = 14;
  localparam longint unsigned DIV5_M = ((64'd1 << DIV5_S) + 64'd4) / 64'd5;

  // leap test, q100 is year / 100
  function automatic logic leap_of(logic [13:0] y, logic [7:0] q100);
    logic cent;
    cent = (y == 14'(14'(q100) * 14'd100));
    return (y[1:0] == 2'd0) && (!cent || (q100[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days from march 1 to the first of month m
  function automatic logic [8:0] march_doy(logic [3:0] m);
    logic [8:0] doy;
    case (m)
      4'd1:    doy = 9'd306;
      4'd2:    doy = 9'd337;
      4'd3:    doy = 9'd0;
      4'd4:    doy = 9'd31;
      4'd5:    doy = 9'd61;
      4'd6:    doy = 9'd92;
      4'd7:    doy = 9'd122;
      4'd8:    doy = 9'd153;
      4'd9:    doy = 9'd184;
      4'd10:   doy = 9'd214;
      4'd11:   doy = 9'd245;
      4'd12:   doy = 9'd275;
      default: doy = 9'd0;
    endcase
    return doy;
  endfunction

endpackage

// ===== rtl/core/cda_target.sv =====
// input check and month / year arithmetic, gives the target date
module cda_target import cda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         cmd,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic signed [22:0] offset,
  output logic               out_vld,
  output cda_meta_t          out_meta,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day
);

  logic [4:0] vld;

  cda_meta_t   meta1, meta2, meta3, meta4, meta5;
  logic [13:0] y1, y2, y3, y4, y5;
  logic [3:0]  m1, m2, m3, m4, m5;
  logic [4:0]  d1, d2, d3, d4, d5;
  logic [7:0]  q1, qn3, q5;
  logic signed [24:0] total2, ny2;
  logic [16:0] tot3;
  logic [13:0] q12_3, ny3;

  logic [63:0] p1, p12, pn, p5;
  logic [7:0]  q1_next, qn_next, q5_next;
  logic [13:0] q12_next;
  logic        leap2, bad2, rng3, leapn4, leap6;
  logic [4:0]  mlen2, mlen6, dyr4, d6;
  logic [3:0]  mm4;
  logic signed [24:0] total_next, ny_next;
  status_t     st2, st3;
  logic [13:0] yt4;
  logic [3:0]  mt4;
  logic [4:0]  dt4;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      out_vld <= 1'b0;
    end else begin
      vld     <= {vld[3:0], start};
      out_vld <= vld[4];
    end
  end

  // stage 1: register the item, year / 100 for the leap test
  assign p1      = 64'(in_year) * DIV100_M;
  assign q1_next = 8'(p1 >> DIV100_S);

  // stage 2: date check, month and year totals
  always_comb begin
    leap2      = leap_of(y1, q1);
    mlen2      = month_len(m1, leap2);
    bad2       = (y1 > MAX_YEAR) || (m1 == 4'd0) || (m1 > 4'd12) ||
                 (d1 == 5'd0) || (d1 > mlen2);
    st2        = bad2 ? ST_BAD_DATE : ST_OK;
    total_next = $signed({11'b0, y1}) * 25'sd12 + $signed({21'b0, m1}) - 25'sd1 +
                 25'(meta1.off);
    ny_next    = $signed({11'b0, y1}) + 25'(meta1.off);
  end

  // stage 3: range check, split the month total, year / 100 of the new year
  always_comb begin
    rng3 = ((meta2.cmd == CMD_ADD_MONTHS) &&
            ((total2 < 25'sd0) || (total2 > $signed({8'b0, MAX_MONTHS})))) ||
           ((meta2.cmd == CMD_ADD_YEARS) &&
            ((ny2 < 25'sd0) || (ny2 > $signed({11'b0, MAX_YEAR}))));
    st3      = (meta2.st == ST_OK && rng3) ? ST_RANGE : meta2.st;
    p12      = 64'(total2[16:0]) * DIV12_M;
    q12_next = 14'(p12 >> DIV12_S);
    pn       = 64'(ny2[13:0]) * DIV100_M;
    qn_next  = 8'(pn >> DIV100_S);
  end

  // stage 4: pick the target date per command
  always_comb begin
    mm4    = 4'(tot3 - 17'(q12_3) * 17'd12) + 4'd1;
    leapn4 = leap_of(ny3, qn3);
    dyr4   = (m3 == 4'd2 && d3 == 5'd29 && !leapn4) ? FEB_SHORT_DAY : d3;
    case (meta3.cmd)
      CMD_ADD_MONTHS: begin
        yt4 = q12_3;
        mt4 = mm4;
        dt4 = d3;
      end
      CMD_ADD_YEARS: begin
        yt4 = ny3;
        mt4 = m3;
        dt4 = dyr4;
      end
      default: begin
        yt4 = y3;
        mt4 = m3;
        dt4 = d3;
      end
    endcase
  end

  // stage 5 / 6: clamp the day after a month step
  assign p5      = 64'(y4) * DIV100_M;
  assign q5_next = 8'(p5 >> DIV100_S);

  always_comb begin
    leap6 = leap_of(y5, q5);
    mlen6 = month_len(m5, leap6);
    d6    = (meta5.cmd == CMD_ADD_MONTHS && d5 > mlen6) ? mlen6 : d5;
  end

  always_ff @(posedge clk) begin
    meta1 <= '{cmd: cmd_t'(cmd), st: ST_OK, off: offset};
    y1    <= in_year;
    m1    <= in_month;
    d1    <= in_day;
    q1    <= q1_next;

    meta2    <= '{cmd: meta1.cmd, st: st2, off: meta1.off};
    y2       <= y1;
    m2       <= m1;
    d2       <= d1;
    total2   <= total_next;
    ny2      <= ny_next;

    meta3    <= '{cmd: meta2.cmd, st: st3, off: meta2.off};
    y3       <= y2;
    m3       <= m2;
    d3       <= d2;
    tot3     <= total2[16:0];
    q12_3    <= q12_next;
    ny3      <= ny2[13:0];
    qn3      <= qn_next;

    meta4 <= meta3;
    y4    <= yt4;
    m4    <= mt4;
    d4    <= dt4;

    meta5 <= meta4;
    y5    <= y4;
    m5    <= m4;
    d5    <= d4;
    q5    <= q5_next;

    out_meta  <= meta5;
    out_year  <= y5;
    out_month <= m5;
    out_day   <= d6;
  end

endmodule

// ===== rtl/core/cda_to_serial.sv =====
// target date to serial day count, day offset and its range check
module cda_to_serial import cda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  cda_meta_t          in_meta,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  output logic               out_vld,
  output status_t            out_st,
  output logic signed [22:0] out_serial
);

  logic        vld1;
  cda_meta_t   meta1;
  logic [13:0] yy1;
  logic [7:0]  q1;
  logic [8:0]  doy1;

  logic [13:0] yy_next;
  logic [63:0] pq;
  logic [7:0]  q_next;
  logic [8:0]  doy_next;
  logic [23:0] days;
  logic signed [25:0] serial, s2;
  logic        rng;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      out_vld <= 1'b0;
    end else begin
      vld1    <= in_vld;
      out_vld <= vld1;
    end
  end

  // year counted from march, shifted one era up
  always_comb begin
    yy_next  = in_year + 14'd400 - {13'b0, (in_month <= 4'd2)};
    pq       = 64'(yy_next) * DIV100_M;
    q_next   = 8'(pq >> DIV100_S);
    doy_next = march_doy(in_month) + 9'(in_day) - 9'd1;
  end

  always_comb begin
    days   = 24'(yy1) * 24'd365 + 24'(yy1 >> 2) - 24'(q1) + 24'(q1 >> 2) + 24'(doy1);
    serial = $signed({2'b0, days}) - ERA_SHIFT;
    s2     = (meta1.cmd == CMD_ADD_DAYS) ? serial + 26'(meta1.off) : serial;
    rng    = (meta1.cmd == CMD_ADD_DAYS) && ((s2 < MIN_SERIAL) || (s2 > MAX_SERIAL));
  end

  always_ff @(posedge clk) begin
    meta1      <= in_meta;
    yy1        <= yy_next;
    q1         <= q_next;
    doy1       <= doy_next;
    out_st     <= (meta1.st == ST_OK && rng) ? ST_RANGE : meta1.st;
    out_serial <= 23'(s2);
  end

endmodule

// ===== rtl/core/cda_from_serial.sv =====
// serial day count back to year, month, day and weekday
module cda_from_serial import cda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  status_t            in_st,
  input  logic signed [22:0] in_serial,
  output logic               done,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic signed [22:0] out_serial,
  output logic [2:0]         out_wday,
  output status_t            out_st
);

  localparam int Depth = 9;

  logic [Depth-1:0]   vld;
  status_t            st    [Depth];
  logic signed [22:0] ser   [Depth];
  logic [4:0]         era   [Depth];
  logic [2:0]         r7    [1:Depth-1];

  logic [21:0] z1, w1;
  logic [18:0] q7_1;
  logic [17:0] doe2, doe3, doe4, doe5, doe6;
  logic [6:0]  a3;
  logic [2:0]  b3;
  logic        c3;
  logic [17:0] t4;
  logic [8:0]  yoe5, yoe6, yoe7, yoe8, yoe9;
  logic [2:0]  qy6;
  logic [8:0]  doy7, doy8, doy9;
  logic [3:0]  mp8, mp9;
  logic [10:0] c9;

  logic signed [23:0] zs, ws;
  logic [63:0] pera, p7, pa, pb, pc, p365, py, p153, p5;
  logic [10:0] x153;
  logic [8:0]  day9;
  logic [3:0]  mm9;
  logic [13:0] y9;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[Depth-2:0], in_vld};
      done <= vld[Depth-1];
    end
  end

  // status, serial, era and weekday remainder ride along
  always_ff @(posedge clk) begin
    st[0]  <= in_st;
    ser[0] <= in_serial;
    era[0] <= 5'(pera >> DIVERA_S);
    r7[1]  <= 3'(w1 - 22'(q7_1) * 22'd7);
    for (int i = 1; i < Depth; i++) begin
      st[i]  <= st[i-1];
      ser[i] <= ser[i-1];
      era[i] <= era[i-1];
    end
    for (int i = 2; i < Depth; i++) begin
      r7[i] <= r7[i-1];
    end
  end

  // stage 1: era and weekday quotient
  always_comb begin
    zs   = 24'(in_serial) + ERA_SHIFT24;
    ws   = 24'(in_serial) + WDAY_SHIFT;
    pera = 64'(zs[21:0]) * DIVERA_M;
    p7   = 64'(ws[21:0]) * DIV7_M;
  end

  always_ff @(posedge clk) begin
    z1   <= zs[21:0];
    w1   <= ws[21:0];
    q7_1 <= 19'(p7 >> DIV7_S);
  end

  // stage 2: day of era
  always_ff @(posedge clk) begin
    doe2 <= 18'(z1 - 22'(era[0]) * 22'd146097);
  end

  // stage 3 / 4: leap corrections, year of era numerator
  always_comb begin
    pa = 64'(doe2) * DIV1460_M;
    pb = 64'(doe2) * DIV36524_M;
    pc = 64'(doe2) * DIV146096_M;
  end

  always_ff @(posedge clk) begin
    doe3 <= doe2;
    a3   <= 7'(pa >> DIV1460_S);
    b3   <= 3'(pb >> DIV36524_S);
    c3   <= 1'(pc >> DIV146096_S);
    doe4 <= doe3;
    t4   <= doe3 - 18'(a3) + 18'(b3) - 18'(c3);
  end

  // stage 5 / 6 / 7: year of era, then day of year from march
  assign p365 = 64'(t4) * DIV365_M;
  assign py   = 64'(yoe5) * DIV100_M;

  always_ff @(posedge clk) begin
    doe5 <= doe4;
    yoe5 <= 9'(p365 >> DIV365_S);
    doe6 <= doe5;
    yoe6 <= yoe5;
    qy6  <= 3'(py >> DIV100_S);
    yoe7 <= yoe6;
    doy7 <= 9'(doe6 - (18'(yoe6) * 18'd365 + 18'(yoe6 >> 2) - 18'(qy6)));
  end

  // stage 8 / 9: month from march, its first day
  always_comb begin
    x153 = 11'(doy7) * 11'd5 + 11'd2;
    p153 = 64'(x153) * DIV153_M;
  end

  always_ff @(posedge clk) begin
    yoe8 <= yoe7;
    doy8 <= doy7;
    mp8  <= 4'(p153 >> DIV153_S);
    yoe9 <= yoe8;
    doy9 <= doy8;
    mp9  <= mp8;
    c9   <= 11'(mp8) * 11'd153 + 11'd2;
  end

  // stage 10: civil date, zeroed on any error
  always_comb begin
    p5   = 64'(c9) * DIV5_M;
    day9 = doy9 - 9'(p5 >> DIV5_S) + 9'd1;
    mm9  = (mp9 < 4'd10) ? mp9 + 4'd3 : mp9 - 4'd9;
    y9   = 14'(yoe9) + 14'(era[Depth-1]) * 14'd400 - 14'd400 + {13'b0, (mm9 <= 4'd2)};
  end

  always_ff @(posedge clk) begin
    out_st <= st[Depth-1];
    if (st[Depth-1] == ST_OK) begin
      out_year   <= y9;
      out_month  <= mm9;
      out_day    <= day9[4:0];
      out_serial <= ser[Depth-1];
      out_wday   <= r7[Depth-1] + 3'd1;
    end else begin
      out_year   <= '0;
      out_month  <= '0;
      out_day    <= '0;
      out_serial <= '0;
      out_wday   <= '0;
    end
  end

endmodule

// ===== rtl/core/calendar_date_arithmetic.sv =====
// top level of the pipelined gregorian date arithmetic unit
// The unit takes one item per clock and never stalls: busy is always low, so
// start may be held high every cycle. Each item gives exactly one result,
// marked by done for one cycle; the receiver must take it then. The pipeline
// has 6 stages of date check and month / year arithmetic, 2 stages to build
// the day count and apply a day offset, and 10 stages that split the day
// count back into a date through constant-reciprocal multiplies.
// Results come out in the order items went in. A bad input date gives
// status 1 and a date beyond 0000-01-01..9999-12-31 gives status 2; in both
// cases every other result field reads zero.
module calendar_date_arithmetic import cda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic signed [22:0] offset,
  output logic               done,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic signed [22:0] serial_days,
  output logic [2:0]         iso_weekday,
  output logic [1:0]         status
);

  // target date after the command
  logic        tgt_vld;
  cda_meta_t   tgt_meta;
  logic [13:0] tgt_year;
  logic [3:0]  tgt_month;
  logic [4:0]  tgt_day;

  // serial day count of the result
  logic               ser_vld;
  status_t            ser_st;
  logic signed [22:0] ser_days;

  status_t res_st;

  // fully pipelined, never holds off an item
  assign busy = 1'b0;

  cda_target u_target (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .offset    (offset),
    .out_vld   (tgt_vld),
    .out_meta  (tgt_meta),
    .out_year  (tgt_year),
    .out_month (tgt_month),
    .out_day   (tgt_day)
  );

  // day offsets are applied here, on the serial count
  cda_to_serial u_to_serial (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (tgt_vld),
    .in_meta    (tgt_meta),
    .in_year    (tgt_year),
    .in_month   (tgt_month),
    .in_day     (tgt_day),
    .out_vld    (ser_vld),
    .out_st     (ser_st),
    .out_serial (ser_days)
  );

  // every command goes back through the split, so the date is normalized
  cda_from_serial u_from_serial (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (ser_vld),
    .in_st      (ser_st),
    .in_serial  (ser_days),
    .done       (done),
    .out_year   (out_year),
    .out_month  (out_month),
    .out_day    (out_day),
    .out_serial (serial_days),
    .out_wday   (iso_weekday),
    .out_st     (res_st)
  );

  assign status = res_st;

`ifndef SYNTHESIS
  // an error result carries no date
  assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> out_year == 14'd0 && out_month == 4'd0 &&
      out_day == 5'd0 && serial_days == 23'sd0 && iso_weekday == 3'd0)
    else $error("error result carries a nonzero date");

  // a good result is a real date with a weekday
  assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OK |-> out_month >= 4'd1 && out_month <= 4'd12 &&
      out_day >= 5'd1 && iso_weekday >= 3'd1 && iso_weekday <= 3'd7 &&
      out_year <= MAX_YEAR)
    else $error("ok result is not a valid date");

  // convert only never leaves the year range
  assert property (@(posedge clk) disable iff (rst)
    tgt_vld && tgt_meta.cmd == CMD_CONVERT |-> tgt_meta.st != ST_RANGE)
    else $error("convert only flagged out of range");
`endif

endmodule

// ===== tb/sv/calendar_date_arithmetic_chk.sv =====
// checker for the date unit: predicts each result and compares it with the one the unit gives
`timescale 1ns / 100ps
module calendar_date_arithmetic_chk import cda_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         cmd,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic signed [22:0] offset,
  input  logic               done,
  input  logic [13:0]        out_year,
  input  logic [3:0]         out_month,
  input  logic [4:0]         out_day,
  input  logic signed [22:0] serial_days,
  input  logic [2:0]         iso_weekday,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [22:0] serial;
    logic [2:0]         wday;
    status_t            st;
  } date_res_t;

  date_res_t expected_dates[$];

  function automatic bit leap_year(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic longint days_in_month(longint y, longint m);
    case (m)
      2: return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic longint day_number(longint y, longint m, longint d);
    longint yy, era, yoe, mp, doy, doe;
    yy  = y + 400 - (m <= 2 ? 1 : 0);
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468 - 146097;
  endfunction

  function automatic date_res_t date_result(logic [1:0] c, logic [13:0] iy, logic [3:0] im,
                                            logic [4:0] id, logic signed [22:0] off_in);
    date_res_t r;
    longint y, m, d, s, off, total, z, era, doe, yoe, doy, mp;
    r   = '0;
    y   = iy;
    m   = im;
    d   = id;
    off = off_in;
    if (y > 9999 || m < 1 || m > 12 || d < 1 || d > days_in_month(y, m)) begin
      r.st = ST_BAD_DATE;
      return r;
    end
    case (cmd_t'(c))
      CMD_ADD_DAYS: begin
        s = day_number(y, m, d) + off;
        if (s < -719528 || s > 2932896) begin
          r.st = ST_RANGE;
          return r;
        end
        z   = s + 719468 + 146097;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        d   = doy - (153 * mp + 2) / 5 + 1;
        y   = yoe + era * 400 - 400 + (m <= 2 ? 1 : 0);
      end
      CMD_ADD_MONTHS: begin
        total = y * 12 + (m - 1) + off;
        if (total < 0 || total > 9999 * 12 + 11) begin
          r.st = ST_RANGE;
          return r;
        end
        y = total / 12;
        m = total % 12 + 1;
        if (d > days_in_month(y, m)) d = days_in_month(y, m);
      end
      CMD_ADD_YEARS: begin
        y = y + off;
        if (y < 0 || y > 9999) begin
          r.st = ST_RANGE;
          return r;
        end
        if (m == 2 && d == 29 && !leap_year(y)) d = 28;
      end
      default: ;
    endcase
    s = day_number(y, m, d);
    r.year   = y[13:0];
    r.month  = m[3:0];
    r.day    = d[4:0];
    r.serial = s[22:0];
    r.wday   = 3'((s + 719528 + 5) % 7 + 1);
    r.st     = ST_OK;
    return r;
  endfunction

  assign pending = expected_dates.size();

  always @(posedge clk) begin
    date_res_t e;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy)
        expected_dates.push_back(date_result(cmd, in_year, in_month, in_day, offset));
      if (done) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result with none expected: %0d-%0d-%0d st %0d", $time,
                   out_year, out_month, out_day, status);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_dates.pop_front();
          if (e.year !== out_year || e.month !== out_month || e.day !== out_day ||
              e.serial !== serial_days || e.wday !== iso_weekday || e.st !== status) begin
            $display("%0t: expected %0d-%0d-%0d serial %0d wday %0d st %0d", $time,
                     e.year, e.month, e.day, e.serial, e.wday, e.st);
            $display("%0t: actual   %0d-%0d-%0d serial %0d wday %0d st %0d", $time,
                     out_year, out_month, out_day, serial_days, iso_weekday, status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/sv/calendar_date_arithmetic_tb.sv =====
// testbench top for the date unit: stimulus, watchdog and verdict
`timescale 1ns / 100ps
module calendar_date_arithmetic_tb import cda_pkg::*;;

  localparam int IDLE_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = CMD_CONVERT;
  logic [13:0]        in_year = '0;
  logic [3:0]         in_month = 4'd1;
  logic [4:0]         in_day = 5'd1;
  logic signed [22:0] offset = '0;
  logic               done;
  logic [13:0]        out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day;
  logic signed [22:0] serial_days;
  logic [2:0]         iso_weekday;
  logic [1:0]         status;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  calendar_date_arithmetic dut (.*);

  calendar_date_arithmetic_chk chk (.*);

  // watchdog: cycles in which no item goes in and no result comes out
  always @(posedge clk) begin
    if ((start && !busy) || done || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called just after a falling edge; returns just after the falling edge that follows the take
  task automatic send(cmd_t c, int y, int m, int d, int off);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd      <= c;
    in_year  <= y[13:0];
    in_month <= m[3:0];
    in_day   <= d[4:0];
    offset   <= off[22:0];
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  function automatic int month_days(int y, int m);
    if (m == 2) return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // random item: mostly a real date with an offset scaled to the command
  task automatic send_random();
    cmd_t c;
    int   y, m, d, off, r;
    c = cmd_t'($urandom_range(3));
    r = $urandom_range(99);
    y = (r < 10) ? $urandom_range(1) * 9999 + ($urandom_range(1) ? -$urandom_range(3) : 0)
                 : $urandom_range(9999);
    if (y < 0) y = 0;
    m = $urandom_range(1, 12);
    d = ($urandom_range(3) == 0) ? month_days(y, m) : $urandom_range(1, month_days(y, m));
    if (r >= 90) begin
      // broken date: every field may be out of its range
      case ($urandom_range(3))
        0: y = $urandom_range(10000, 16383);
        1: m = ($urandom_range(1)) ? 0 : $urandom_range(13, 15);
        2: d = ($urandom_range(1)) ? 0 : $urandom_range(month_days(y, m) + 1, 31);
        default: begin
          y = $urandom_range(16383);
          m = $urandom_range(15);
          d = $urandom_range(31);
        end
      endcase
    end
    r = $urandom_range(99);
    if (r < 10) begin
      off = $signed(23'($urandom));
    end else begin
      case (c)
        CMD_ADD_DAYS:   off = $urandom_range(0, 7300000) - 3650000;
        CMD_ADD_MONTHS: off = (r < 50) ? $urandom_range(0, 48) - 24
                                       : $urandom_range(0, 240000) - 120000;
        CMD_ADD_YEARS:  off = (r < 50) ? $urandom_range(0, 16) - 8
                                       : $urandom_range(0, 20000) - 10000;
        default:        off = $signed(23'($urandom));
      endcase
    end
    send(c, y, m, d, off);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: range ends, leap cases, bad dates, each command
    send(CMD_CONVERT, 0, 1, 1, 0);
    send(CMD_CONVERT, 9999, 12, 31, -1);
    send(CMD_CONVERT, 1970, 1, 1, 4194303);
    send(CMD_CONVERT, 2000, 2, 29, 0);
    send(CMD_CONVERT, 1900, 2, 29, 0);
    send(CMD_CONVERT, 2001, 0, 10, 0);
    send(CMD_CONVERT, 2001, 15, 10, 0);
    send(CMD_CONVERT, 2001, 4, 0, 0);
    send(CMD_CONVERT, 2001, 4, 31, 0);
    send(CMD_CONVERT, 10000, 1, 1, 0);
    send(CMD_CONVERT, 16383, 15, 31, 0);
    send(CMD_ADD_DAYS, 9999, 12, 31, 1);
    send(CMD_ADD_DAYS, 0, 1, 1, -1);
    send(CMD_ADD_DAYS, 0, 1, 1, 3652058);
    send(CMD_ADD_DAYS, 2000, 1, 1, 4194303);
    send(CMD_ADD_DAYS, 2000, 1, 1, -4194304);
    send(CMD_ADD_MONTHS, 2000, 1, 31, -1);
    send(CMD_ADD_MONTHS, 2000, 1, 31, 1);
    send(CMD_ADD_MONTHS, 2001, 1, 31, 1);
    send(CMD_ADD_MONTHS, 9999, 12, 1, 1);
    send(CMD_ADD_MONTHS, 0, 1, 1, -1);
    send(CMD_ADD_YEARS, 2000, 2, 29, 1);
    send(CMD_ADD_YEARS, 2000, 2, 29, 4);
    send(CMD_ADD_YEARS, 2000, 2, 29, -2001);
    send(CMD_ADD_YEARS, 5000, 6, 15, -4194304);

    repeat (650) send_random();
    start <= 1'b0;

    wait (pending == 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
